@@ sv/hids_pkg.sv @@
// ----------------------------------------------------------------------------
// hids_pkg
// Types and constants shared by the ID hash stack modules.
// ----------------------------------------------------------------------------
package hids_pkg;

	typedef logic [63:0] id_t;

	// item kinds
	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_PUSH  = 2'd1;
	localparam logic [1:0] KIND_BYTE  = 2'd2;
	localparam logic [1:0] KIND_POP   = 2'd3;

	localparam id_t FNV_BASIS  = 64'hCBF2_9CE4_8422_2325;
	localparam id_t MIX_GOLDEN = 64'h0000_0000_9E37_79B9;

	typedef struct packed {
		logic [1:0] kind;
		logic [63:0] value;
		logic [7:0] byte_value;
		logic last_byte;
	} req_t;

	typedef struct packed {
		logic [63:0] top_id;
		logic [6:0] stack_depth;
		logic overflow;
	} rsp_t;

endpackage

@@ sv/hierarchical_id_hash_stack_core.sv @@
// ----------------------------------------------------------------------------
// hierarchical_id_hash_stack_core
// Widget ID stack with FNV-1a string hashing, held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one item: frame reset,
//   numeric push, string byte or pop. rsp channel (rsp_valid/rsp_ready/rsp)
//   returns exactly one transfer per item: top ID, depth and overflow flag.
//   States between acceptance and the loaded result, by kind:
//     frame reset, numeric push, pop with one entry or none : EMIT
//     pop with more entries (RAM read of the new top)        : POP, EMIT
//     string byte, not last (prime multiply)                 : MUL, EMIT
//     last string byte (multiply, then push the hash)        : MUL, PUSH, EMIT
//   The block takes its next item only once the result is loaded and it is
//   back in IDLE; the registered RAM read and the split of the hash multiply
//   from the combine add the POP and MUL states. The top entry is cached in a
//   register so that pushes never wait on the RAM.
//   Reset empties the stack and returns the hash to the offset basis; RAM
//   contents are left as they are and are only read below the fill count.
//   A stalled receiver holds the result register; the block may accept and
//   work on one more item meanwhile and then waits until the register frees.
// ----------------------------------------------------------------------------
module hierarchical_id_hash_stack_core #(
	parameter int STACK_DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input hids_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output hids_pkg::rsp_t rsp
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PUSH = 3'd2;
	localparam logic [2:0] ST_POP  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [CW-1:0] count_q;
	hids_pkg::id_t top_q;
	hids_pkg::id_t hash_q;
	logic last_q;
	logic ovf_q;
	logic rsp_valid_q;
	hids_pkg::rsp_t rsp_q;

	logic accept;
	logic full;
	logic empty;
	logic push_go;
	logic pop_go;
	logic emit_go;
	hids_pkg::id_t push_src;
	hids_pkg::id_t push_val;
	hids_pkg::id_t fnv_out;
	hids_pkg::id_t byte_ext;
	hids_pkg::id_t rd_data;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	hids_pkg::id_t ram_wdata;
	logic [CW-1:0] pop_idx;
	logic [CW+6:0] count_ext;

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;

	assign full = (count_q >= CW'(STACK_DEPTH));
	assign empty = (count_q == '0);
	assign byte_ext = {{56{req.byte_value[7]}}, req.byte_value};

	// a push comes from a numeric item or from the end of a string
	assign push_go = (accept && req.kind == hids_pkg::KIND_PUSH) || (state_q == ST_PUSH);
	assign push_src = (state_q == ST_PUSH) ? hash_q : req.value;

	// pop with more than one entry: fetch the entry below the top
	assign pop_go = accept && (req.kind == hids_pkg::KIND_POP) && (count_q > CW'(1));
	assign pop_idx = count_q - CW'(2);

	assign emit_go = (state_q == ST_EMIT) && (!rsp_valid_q || rsp_ready);

	hids_mix u_mix (
		.parent(top_q),
		.child(push_src),
		.empty(empty),
		.result(push_val)
	);

	hids_fnv u_fnv (
		.h(hash_q),
		.p(fnv_out)
	);

	// RAM write: frame reset writes root 0, a push writes at the fill count
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = push_val;
		if (accept && req.kind == hids_pkg::KIND_FRAME) begin
			ram_we = 1'b1;
			ram_waddr = '0;
			ram_wdata = '0;
		end else if (push_go && !full) begin
			ram_we = 1'b1;
		end
	end

	hids_ram #(
		.DEPTH(STACK_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(pop_go),
		.raddr(pop_idx[AW-1:0]),
		.rdata(rd_data)
	);

	// sequencer and stack state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			top_q <= '0;
			hash_q <= hids_pkg::FNV_BASIS;
			last_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			if (push_go) begin
				// drop the push on a full stack, flag it
				ovf_q <= full;
				if (!full) begin
					top_q <= push_val;
					count_q <= count_q + CW'(1);
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.kind)
							hids_pkg::KIND_FRAME: begin
								count_q <= CW'(1);
								top_q <= '0;
								ovf_q <= 1'b0;
								state_q <= ST_EMIT;
							end
							hids_pkg::KIND_PUSH: begin
								state_q <= ST_EMIT;
							end
							hids_pkg::KIND_BYTE: begin
								hash_q <= hash_q ^ byte_ext;
								last_q <= req.last_byte;
								ovf_q <= 1'b0;
								state_q <= ST_MUL;
							end
							default: begin
								ovf_q <= 1'b0;
								if (pop_go) begin
									count_q <= count_q - CW'(1);
									state_q <= ST_POP;
								end else begin
									state_q <= ST_EMIT;
								end
							end
						endcase
					end
				end
				ST_MUL: begin
					hash_q <= fnv_out;
					state_q <= last_q ? ST_PUSH : ST_EMIT;
				end
				ST_PUSH: begin
					// restart the hash for the next string
					hash_q <= hids_pkg::FNV_BASIS;
					state_q <= ST_EMIT;
				end
				ST_POP: begin
					top_q <= rd_data;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register: hold until the transfer completes
	assign count_ext = {7'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			rsp_q.top_id <= empty ? '0 : top_q;
			rsp_q.stack_depth <= count_ext[6:0];
			rsp_q.overflow <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

@@ sv/hids_ram.sv @@
// ----------------------------------------------------------------------------
// hids_ram
// Single-port-write, single-port-read ID store with registered read data.
// ----------------------------------------------------------------------------
module hids_ram #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input hids_pkg::id_t wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output hids_pkg::id_t rdata
);

	hids_pkg::id_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/hids_mix.sv @@
// ----------------------------------------------------------------------------
// hids_mix
// Push value selection: raw value on an empty stack, else combine(top, value).
// ----------------------------------------------------------------------------
module hids_mix (
	input hids_pkg::id_t parent,
	input hids_pkg::id_t child,
	input logic empty,
	output hids_pkg::id_t result
);

	hids_pkg::id_t sum;

	// four-operand add, all modulo 2^64
	assign sum = child + hids_pkg::MIX_GOLDEN + {parent[57:0], 6'b0} + {2'b0, parent[63:2]};
	assign result = empty ? child : (parent ^ sum);

endmodule

@@ sv/hids_fnv.sv @@
// ----------------------------------------------------------------------------
// hids_fnv
// FNV-1a prime multiply, modulo 2^64, as a shift-add over the prime's bits.
// ----------------------------------------------------------------------------
module hids_fnv (
	input hids_pkg::id_t h,
	output hids_pkg::id_t p
);

	// prime = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
	assign p = {h[23:0], 40'b0} + {h[55:0], 8'b0} + {h[56:0], 7'b0}
		+ {h[58:0], 5'b0} + {h[59:0], 4'b0} + {h[62:0], 1'b0} + h;

endmodule

@@ tb/sv/hierarchical_id_hash_stack_core_tb.sv @@
// ----------------------------------------------------------------------------
// hierarchical_id_hash_stack_core_tb
// Self-checking bench for the widget ID hash stack. A queue of items (frame
// resets, numeric pushes, string bytes, pops) feeds a bursty driver. A
// shadow stack predicts each result, and a monitor compares every result
// transfer against that prediction while the receiver stalls at random.
// ----------------------------------------------------------------------------
module hierarchical_id_hash_stack_core_tb;

	localparam int STACK_DEPTH = 64;
	localparam hids_pkg::id_t FNV_PRIME = 64'h0000_0100_0000_01B3;
	localparam int RANDOM_ITEMS = 1050;
	localparam int QUIET_LIMIT = 2000;   // cycles with no transfer on either side
	localparam int HOLD_CYCLES = 400;    // long receiver hold-off
	localparam int DRAIN_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	hids_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	hids_pkg::rsp_t rsp;

	hierarchical_id_hash_stack_core #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Shadow stack: mirrors the ID store, the fill count and the running
	// FNV-1a hash, and works out the result of each accepted item.
	// ------------------------------------------------------------------
	hids_pkg::id_t id_shadow [STACK_DEPTH];
	int shadow_count = 0;
	hids_pkg::id_t fnv_state = hids_pkg::FNV_BASIS;

	int strings_hashed = 0;
	int dropped_pushes = 0;
	int moving_pops = 0;
	int peak_depth = 0;

	function automatic hids_pkg::id_t mix_ids(hids_pkg::id_t parent, hids_pkg::id_t child);
		return parent ^ (child + hids_pkg::MIX_GOLDEN + (parent << 6) + (parent >> 2));
	endfunction

	// Push onto the shadow stack; an empty stack takes the value raw.
	// Returns 1 when the push is dropped on a full stack.
	function automatic logic push_shadow(hids_pkg::id_t v);
		if (shadow_count >= STACK_DEPTH) begin
			dropped_pushes++;
			return 1'b1;
		end
		if (shadow_count == 0)
			id_shadow[0] = v;
		else
			id_shadow[shadow_count] = mix_ids(id_shadow[shadow_count - 1], v);
		shadow_count++;
		if (shadow_count > peak_depth)
			peak_depth = shadow_count;
		return 1'b0;
	endfunction

	function automatic hids_pkg::rsp_t apply_id_item(hids_pkg::req_t it);
		hids_pkg::rsp_t r;
		logic dropped;
		dropped = 1'b0;
		case (it.kind)
			hids_pkg::KIND_FRAME: begin
				id_shadow[0] = '0;
				shadow_count = 1;
			end
			hids_pkg::KIND_PUSH: begin
				dropped = push_shadow(it.value);
			end
			hids_pkg::KIND_BYTE: begin
				// the byte is a signed char: sign-extend before the XOR
				fnv_state = (fnv_state ^ {{56{it.byte_value[7]}}, it.byte_value}) * FNV_PRIME;
				if (it.last_byte) begin
					dropped = push_shadow(fnv_state);
					fnv_state = hids_pkg::FNV_BASIS;
					strings_hashed++;
				end
			end
			default: begin
				// never pop the last entry
				if (shadow_count > 1) begin
					shadow_count--;
					moving_pops++;
				end
			end
		endcase
		r.top_id = (shadow_count == 0) ? '0 : id_shadow[shadow_count - 1];
		r.stack_depth = shadow_count[6:0];
		r.overflow = dropped;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	hids_pkg::req_t id_items [$];
	int items_total = 0;
	bit stim_ready = 1'b0;

	function automatic hids_pkg::id_t rand_id();
		return {$urandom, $urandom};
	endfunction

	// Lean on the extremes now and then, otherwise anything goes.
	function automatic hids_pkg::id_t pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'h1;
			3: return 64'h8000_0000_0000_0000;
			4: return hids_pkg::FNV_BASIS;
			default: return rand_id();
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'h7F;
			2: return 8'h80;
			3: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Queue one item; fields that the kind ignores carry random junk.
	task automatic queue_item(logic [1:0] k, hids_pkg::id_t v, logic [7:0] b, logic l);
		hids_pkg::req_t it;
		it.kind = k;
		it.value = (k == hids_pkg::KIND_PUSH) ? v : rand_id();
		it.byte_value = (k == hids_pkg::KIND_BYTE) ? b : 8'($urandom);
		it.last_byte = (k == hids_pkg::KIND_BYTE) ? l : 1'($urandom);
		id_items = {id_items, it};
	endtask

	// A whole string ID; an empty string goes as a numeric push of the basis.
	task automatic queue_string(int len);
		if (len == 0)
			queue_item(hids_pkg::KIND_PUSH, hids_pkg::FNV_BASIS, '0, 1'b0);
		for (int i = 0; i < len; i++)
			queue_item(hids_pkg::KIND_BYTE, '0, pick_byte(), i == len - 1);
	endtask

	// Push well past full from wherever the depth stands, then climb down.
	task automatic queue_fill_run();
		repeat (STACK_DEPTH + 2) begin
			if ($urandom_range(0, 3) == 0)
				queue_string(1);
			else
				queue_item(hids_pkg::KIND_PUSH, pick_value(), '0, 1'b0);
		end
		queue_string(2);   // dropped, yet the hash must still restart
		queue_item(hids_pkg::KIND_PUSH, pick_value(), '0, 1'b0);
		repeat ($urandom_range(1, 40))
			queue_item(hids_pkg::KIND_POP, '0, '0, 1'b0);
	endtask

	initial begin : build_items
		int choice;
		// directed opening: empty stack, sign extension, extremes, pops
		queue_item(hids_pkg::KIND_POP, '0, '0, 1'b0);          // pop on empty
		queue_item(hids_pkg::KIND_BYTE, '0, 8'h80, 1'b0);      // negative byte
		queue_item(hids_pkg::KIND_PUSH, '1, '0, 1'b0);         // raw push on empty
		queue_item(hids_pkg::KIND_BYTE, '0, 8'hFF, 1'b1);      // string ends, combine
		queue_item(hids_pkg::KIND_PUSH, '0, '0, 1'b0);
		queue_item(hids_pkg::KIND_PUSH, 64'h8000_0000_0000_0000, '0, 1'b0);
		queue_item(hids_pkg::KIND_BYTE, '0, 8'h7F, 1'b0);
		queue_item(hids_pkg::KIND_BYTE, '0, 8'h00, 1'b0);
		queue_item(hids_pkg::KIND_BYTE, '0, 8'h01, 1'b1);
		queue_item(hids_pkg::KIND_PUSH, hids_pkg::FNV_BASIS, '0, 1'b0);  // empty string
		repeat (6)
			queue_item(hids_pkg::KIND_POP, '0, '0, 1'b0);      // last one hits the floor
		queue_item(hids_pkg::KIND_FRAME, '0, '0, 1'b0);
		queue_item(hids_pkg::KIND_POP, '0, '0, 1'b0);          // pop with one entry
		queue_item(hids_pkg::KIND_PUSH, 64'h1, '0, 1'b0);
		queue_item(hids_pkg::KIND_BYTE, '0, 8'hFE, 1'b1);
		queue_item(hids_pkg::KIND_FRAME, '0, '0, 1'b0);

		// random part, opened by one guaranteed run to a full stack
		items_total = id_items.size() + RANDOM_ITEMS;
		queue_fill_run();
		while (id_items.size() < items_total) begin
			choice = $urandom_range(0, 99);
			if (choice < 5)
				queue_item(hids_pkg::KIND_FRAME, '0, '0, 1'b0);
			else if (choice < 35)
				queue_item(hids_pkg::KIND_PUSH, pick_value(), '0, 1'b0);
			else if (choice < 60)
				queue_string(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
			else if (choice < 80)
				repeat ($urandom_range(1, 4))
					queue_item(hids_pkg::KIND_POP, '0, '0, 1'b0);
			else if (choice == 80)
				queue_fill_run();
			else
				// noise: any kind, any fields, strings cut short included
				queue_item(2'($urandom), rand_id(), 8'($urandom), 1'($urandom));
		end
		items_total = id_items.size();
		stim_ready = 1'b1;
	end

	// ------------------------------------------------------------------
	// Driver: bursts of random length with random gaps. Valid holds with
	// the payload unchanged until the transfer happens.
	// ------------------------------------------------------------------
	bit req_taken = 1'b0;    // set at the rising edge that accepted an item
	int burst_left = 8;
	int gap_left = 0;

	always @(negedge clk) begin
		if (arst_n && stim_ready && (!req_valid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (id_items.size() > 0) begin
				req <= id_items.pop_front();
				req_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					// now and then a long burst with no idling at all
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
					                                         : $urandom_range(1, 12);
					gap_left = $urandom_range(0, 10);
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: cycles through stall patterns; the hold-off process can
	// force a long stretch of not-ready on top.
	// ------------------------------------------------------------------
	bit hold_rsp = 1'b0;
	int rsp_mode = 0;
	int mode_left = 0;
	int mode_tick = 0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			rsp_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(16, 80);
		end
		mode_left--;
		mode_tick++;
		if (hold_rsp || !arst_n)
			rsp_ready <= 1'b0;
		else
			case (rsp_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= 1'($urandom);
				2: rsp_ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ready <= (mode_tick % 3 == 0);
			endcase
	end

	int items_taken = 0;

	// Hold the receiver off while the sender keeps offering, so the block
	// fills up and has to drop its ready.
	initial begin : receiver_hold
		while (items_taken < 320)
			@(posedge clk);
		hold_rsp = 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		hold_rsp = 1'b0;
	end

	// ------------------------------------------------------------------
	// Monitor and checker
	// ------------------------------------------------------------------
	hids_pkg::rsp_t awaited_views [$];
	int mismatches = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	task automatic report_mismatch(string what);
		mismatches++;
		$display("mismatch at result %0d: %s", results_seen, what);
	endtask

	always @(posedge clk) begin
		hids_pkg::rsp_t want;
		if (arst_n) begin
			req_taken = req_valid && req_ready;
			// predict at acceptance, so the view matches the order of transfers
			if (req_taken) begin
				awaited_views = {awaited_views, apply_id_item(req)};
				items_taken++;
			end
			if (rsp_valid && rsp_ready) begin
				if (awaited_views.size() == 0) begin
					report_mismatch("result transfer with nothing awaited");
				end else begin
					want = awaited_views.pop_front();
					if (rsp.top_id !== want.top_id)
						report_mismatch($sformatf("top_id %h, predicted %h",
							rsp.top_id, want.top_id));
					if (rsp.stack_depth !== want.stack_depth)
						report_mismatch($sformatf("stack_depth %0d, predicted %0d",
							rsp.stack_depth, want.stack_depth));
					if (rsp.overflow !== want.overflow)
						report_mismatch($sformatf("overflow %b, predicted %b",
							rsp.overflow, want.overflow));
				end
				results_seen++;
			end
			if (req_taken || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Watchdog: drop out when neither side has moved for too long.
	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("timeout: no transfer for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, awaited_views.size());
		$display("hierarchical_id_hash_stack_core_tb: errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// End of run: all items in, all results back, then a short drain to
	// catch any stray result.
	// ------------------------------------------------------------------
	initial begin : run_end
		while (!stim_ready || items_taken < items_total)
			@(posedge clk);
		while (awaited_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (awaited_views.size() != 0)
			report_mismatch("results still awaited after drain");
		$display("covered %0d items: %0d string ids hashed, %0d pops that moved the top",
			items_taken, strings_hashed, moving_pops);
		$display("stack peaked at %0d entries, %0d pushes dropped on a full stack",
			peak_depth, dropped_pushes);
		if (mismatches == 0)
			$display("hierarchical_id_hash_stack_core_tb: clean");
		else
			$display("hierarchical_id_hash_stack_core_tb: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/hids_pkg.sv
sv/hids_ram.sv
sv/hids_mix.sv
sv/hids_fnv.sv
sv/hierarchical_id_hash_stack_core.sv
tb/sv/hierarchical_id_hash_stack_core_tb.sv
